// File: sv/ipoc_pkg.sv
// Package for the image pixel to occupancy cell block: payload and
// configuration types, register indexes, widths and fixed values.
// It has no dependencies and is compiled first.
package ipoc_pkg;

	localparam int DIM_W    = 13;
	localparam int MAX_DIM  = 4096;
	localparam int THR_W    = 17;
	localparam int SUM_W    = 10;
	localparam int PROD_W   = 28;
	localparam int QUOT_W   = 7;
	localparam int REM_W    = PROD_W + QUOT_W;
	localparam int DIVR_W   = PROD_W + QUOT_W - 1;
	localparam int IDX_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_NEGATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRINARY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OCC_THR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_THR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd6;

	localparam logic [THR_W-1:0] OCC_THR_RESET  = 17'd42598;
	localparam logic [THR_W-1:0] FREE_THR_RESET = 17'd12780;

	localparam logic [QUOT_W-1:0] SCALE_MAX = 7'd99;
	localparam logic signed [7:0] VAL_OCCUPIED = 8'sd100;
	localparam logic signed [7:0] VAL_FREE     = 8'sd0;
	localparam logic signed [7:0] VAL_UNKNOWN  = -8'sd1;
	localparam logic signed [7:0] VAL_SAT      = 8'sd99;

	typedef enum logic [2:0] {
		KIND_OCCUPIED,
		KIND_FREE,
		KIND_UNKNOWN,
		KIND_SAT,
		KIND_SCALE
	} kind_t;

	typedef struct packed {
		logic [7:0]  chan0;
		logic [7:0]  chan1;
		logic [7:0]  chan2;
		logic [7:0]  chan3;
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic signed [7:0] cell_value;
		logic [IDX_W-1:0]  cell_index;
	} occ_cell_t;

	typedef struct packed {
		logic             negate;
		logic             trinary_mode;
		logic [2:0]       channel_count;
		logic [THR_W-1:0] occupied_threshold;
		logic [THR_W-1:0] free_threshold;
		logic [DIM_W-1:0] map_width;
		logic [DIM_W-1:0] map_height;
	} cfg_t;

	// Item travelling through the divider cells.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [DIVR_W-1:0] divr;
		logic [QUOT_W-1:0] quot;
		kind_t             kind;
		logic [IDX_W-1:0]  index;
	} div_t;

endpackage

// File: sv/image_pixel_to_occupancy_cell.sv
// Top level of the image pixel to occupancy cell block: configuration
// registers, front pipeline and the chain of divider cells.
// Depends on ipoc_pkg, ipoc_front and ipoc_div_cell.
//
//   channel   direction  handshake               payload
//   pix       in         pix_valid / pix_stall   ipoc_pkg::pixel_t
//   occ       out        occ_valid / occ_stall   ipoc_pkg::occ_cell_t
//   cfg       in         cfg_we                  cfg_index, cfg_data
//
// One pixel can transfer on every clock unless pix_stall is high; each
// result passes four front stages and then seven divider cells, one cell
// for each bit of the 0..99 quotient.
// Reset clears every stage's valid bit and returns the registers to their
// defaults. Each stage holds only while it is full and the stage after it
// holds, so empty slots close up and a stalled output does not stop the
// input until the whole chain is full.
module image_pixel_to_occupancy_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  ipoc_pkg::pixel_t                      pix,
	output logic                                  occ_valid,
	input  logic                                  occ_stall,
	output ipoc_pkg::occ_cell_t                   occ,
	input  logic                                  cfg_we,
	input  logic [ipoc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ipoc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers. The user must change them only while the pipeline
	// is empty; the block does not enforce this. Every stage reads them directly.
	ipoc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.negate             <= 1'b0;
			cfg_q.trinary_mode       <= 1'b1;
			cfg_q.channel_count      <= 3'd1;
			cfg_q.occupied_threshold <= ipoc_pkg::OCC_THR_RESET;
			cfg_q.free_threshold     <= ipoc_pkg::FREE_THR_RESET;
			cfg_q.map_width          <= 13'(ipoc_pkg::MAX_DIM);
			cfg_q.map_height         <= 13'(ipoc_pkg::MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipoc_pkg::CFG_NEGATE:     cfg_q.negate <= cfg_data[0];
				ipoc_pkg::CFG_TRINARY:    cfg_q.trinary_mode <= cfg_data[0];
				ipoc_pkg::CFG_CHAN_COUNT: cfg_q.channel_count <= cfg_data[2:0];
				ipoc_pkg::CFG_OCC_THR:    cfg_q.occupied_threshold <= cfg_data;
				ipoc_pkg::CFG_FREE_THR:   cfg_q.free_threshold <= cfg_data;
				ipoc_pkg::CFG_MAP_WIDTH:  cfg_q.map_width <= cfg_data[12:0];
				ipoc_pkg::CFG_MAP_HEIGHT: cfg_q.map_height <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Link signals: entry 0 is the front output, entry i+1 the output of cell i.
	ipoc_pkg::div_t link_data  [ipoc_pkg::QUOT_W+1];
	logic           link_valid [ipoc_pkg::QUOT_W+1];
	logic           link_stall [ipoc_pkg::QUOT_W+1];

	ipoc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (pix_valid),
		.in_stall  (pix_stall),
		.in_data   (pix),
		.out_valid (link_valid[0]),
		.out_stall (link_stall[0]),
		.out_data  (link_data[0])
	);

	// The divisor starts aligned to the top quotient bit and each cell
	// shifts it down by one, so all cells are identical.
	for (genvar i = 0; i < ipoc_pkg::QUOT_W; i++) begin : g_cell
		ipoc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_stall  (link_stall[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_stall (link_stall[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	assign link_stall[ipoc_pkg::QUOT_W] = occ_stall;

	// Result mapping from the last cell's registers; it is stable while stalled.
	ipoc_pkg::div_t last;
	assign last = link_data[ipoc_pkg::QUOT_W];

	always_comb begin
		occ.cell_index = last.index;
		unique case (last.kind)
			ipoc_pkg::KIND_OCCUPIED: occ.cell_value = ipoc_pkg::VAL_OCCUPIED;
			ipoc_pkg::KIND_FREE:     occ.cell_value = ipoc_pkg::VAL_FREE;
			ipoc_pkg::KIND_UNKNOWN:  occ.cell_value = ipoc_pkg::VAL_UNKNOWN;
			ipoc_pkg::KIND_SAT:      occ.cell_value = ipoc_pkg::VAL_SAT;
			ipoc_pkg::KIND_SCALE: begin
				// The quotient never exceeds 99 for a scaled cell; clamp anyway.
				occ.cell_value = (last.quot > ipoc_pkg::SCALE_MAX) ?
				                 ipoc_pkg::VAL_SAT : $signed({1'b0, last.quot});
			end
			default:                 occ.cell_value = ipoc_pkg::VAL_UNKNOWN;
		endcase
	end

	assign occ_valid = link_valid[ipoc_pkg::QUOT_W];

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_valid |-> (occ.cell_value >= ipoc_pkg::VAL_UNKNOWN) &&
		              (occ.cell_value <= ipoc_pkg::VAL_OCCUPIED))
		else $error("cell value out of range");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_valid && last.kind == ipoc_pkg::KIND_SCALE |->
		last.quot <= ipoc_pkg::SCALE_MAX)
		else $error("scaled quotient above 99");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> occ_valid && occ_stall)
		else $error("input stalled while the output is free");

endmodule

// File: sv/ipoc_front.sv
// Front pipeline of the occupancy block: channel averaging, threshold
// products, classification and the scaled dividend, over four stages.
// Depends on ipoc_pkg.
module ipoc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  ipoc_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  ipoc_pkg::pixel_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ipoc_pkg::div_t     out_data
);

	// Stage 1: channel sum and pixel level.
	logic [2:0]  n_chan;
	logic [2:0]  n_avg;
	logic [7:0]  chans [4];
	logic [ipoc_pkg::SUM_W-1:0] sum;
	logic [ipoc_pkg::SUM_W:0]   full_wide;
	logic [ipoc_pkg::SUM_W-1:0] full;
	logic        alpha_zero;
	logic [ipoc_pkg::IDX_W-1:0] inv_row;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        stall_s1, stall_s2, stall_s3, stall_s4;

	logic [ipoc_pkg::SUM_W-1:0] lvl_s1;
	logic [ipoc_pkg::SUM_W-1:0] full_s1;
	logic                       unk_s1;
	logic [ipoc_pkg::IDX_W-1:0] inv_row_s1;
	logic [11:0]                col_s1;

	always_comb begin
		priority if (cfg.channel_count == 3'd0) begin
			n_chan = 3'd1;
		end else if (cfg.channel_count > 3'd4) begin
			n_chan = 3'd4;
		end else begin
			n_chan = cfg.channel_count;
		end
		n_avg = (cfg.trinary_mode || n_chan == 3'd1) ? n_chan : n_chan - 3'd1;
		chans[0] = in_data.chan0;
		chans[1] = in_data.chan1;
		chans[2] = in_data.chan2;
		chans[3] = in_data.chan3;
		sum = '0;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < n_avg) begin
				sum = sum + ipoc_pkg::SUM_W'(chans[k]);
			end
		end
		unique case (n_chan)
			3'd2:    alpha_zero = (in_data.chan1 == 8'd0);
			3'd3:    alpha_zero = (in_data.chan2 == 8'd0);
			3'd4:    alpha_zero = (in_data.chan3 == 8'd0);
			default: alpha_zero = 1'b0;
		endcase
		full_wide = (11'(n_avg) << 8) - 11'(n_avg);
		full = full_wide[ipoc_pkg::SUM_W-1:0];
		inv_row = ipoc_pkg::IDX_W'(cfg.map_height > 13'(ipoc_pkg::MAX_DIM) ?
		          13'(ipoc_pkg::MAX_DIM) : cfg.map_height)
		          - 24'd1 - 24'(in_data.pixel_row);
	end

	assign stall_s4 = v_s4 && out_stall;
	assign stall_s3 = v_s3 && stall_s4;
	assign stall_s2 = v_s2 && stall_s3;
	assign stall_s1 = v_s1 && stall_s2;
	assign in_stall = stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!stall_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1) begin
			lvl_s1     <= cfg.negate ? sum : full - sum;
			full_s1    <= full;
			unk_s1     <= cfg.trinary_mode || alpha_zero;
			inv_row_s1 <= inv_row;
			col_s1     <= in_data.pixel_col;
		end
	end

	// Stage 2: level and thresholds scaled to a common denominator, grid row offset.
	logic [ipoc_pkg::DIM_W-1:0]  width_c;
	logic [ipoc_pkg::DIM_W+ipoc_pkg::IDX_W-1:0] row_off;
	logic [ipoc_pkg::PROD_W-1:0] sx_s2, occ_full_s2, free_full_s2;
	logic                        unk_s2;
	logic [ipoc_pkg::IDX_W-1:0]  row_off_s2;
	logic [11:0]                 col_s2;

	assign width_c = (cfg.map_width > 13'(ipoc_pkg::MAX_DIM)) ?
	                 13'(ipoc_pkg::MAX_DIM) : cfg.map_width;
	assign row_off = (ipoc_pkg::DIM_W + ipoc_pkg::IDX_W)'(width_c) *
	                 (ipoc_pkg::DIM_W + ipoc_pkg::IDX_W)'(inv_row_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!stall_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2) begin
			sx_s2        <= {2'b00, lvl_s1, 16'd0};
			occ_full_s2  <= ipoc_pkg::PROD_W'(cfg.occupied_threshold) *
			                ipoc_pkg::PROD_W'(full_s1);
			free_full_s2 <= ipoc_pkg::PROD_W'(cfg.free_threshold) *
			                ipoc_pkg::PROD_W'(full_s1);
			unk_s2       <= unk_s1;
			row_off_s2   <= row_off[ipoc_pkg::IDX_W-1:0];
			col_s2       <= col_s1;
		end
	end

	// Stage 3: classification.
	ipoc_pkg::kind_t             kind;
	ipoc_pkg::kind_t             kind_s3;
	logic [ipoc_pkg::PROD_W-1:0] num_s3, den_s3;
	logic [ipoc_pkg::IDX_W-1:0]  index_s3;

	always_comb begin
		priority if (sx_s2 > occ_full_s2) begin
			kind = ipoc_pkg::KIND_OCCUPIED;
		end else if (sx_s2 < free_full_s2) begin
			kind = ipoc_pkg::KIND_FREE;
		end else if (unk_s2) begin
			kind = ipoc_pkg::KIND_UNKNOWN;
		end else if (cfg.occupied_threshold <= cfg.free_threshold) begin
			kind = ipoc_pkg::KIND_SAT;
		end else begin
			kind = ipoc_pkg::KIND_SCALE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (!stall_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s3) begin
			kind_s3  <= kind;
			num_s3   <= sx_s2 - free_full_s2;
			den_s3   <= occ_full_s2 - free_full_s2;
			index_s3 <= row_off_s2 + ipoc_pkg::IDX_W'(col_s2);
		end
	end

	// Stage 4: dividend 99 * num and the divisor aligned to the top quotient bit.
	ipoc_pkg::div_t div_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (!stall_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s4) begin
			div_s4.rem   <= ipoc_pkg::REM_W'(num_s3) *
			                ipoc_pkg::REM_W'(ipoc_pkg::SCALE_MAX);
			div_s4.divr  <= {den_s3, {(ipoc_pkg::QUOT_W-1){1'b0}}};
			div_s4.quot  <= '0;
			div_s4.kind  <= kind_s3;
			div_s4.index <= index_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = div_s4;

endmodule

// File: sv/ipoc_div_cell.sv
// One restoring-division cell: resolves one quotient bit per item and
// hands the item to the next cell. Depends on ipoc_pkg.
module ipoc_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ipoc_pkg::div_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output ipoc_pkg::div_t  out_data
);

	logic           v_q;
	ipoc_pkg::div_t data_q;
	logic           take;
	logic [ipoc_pkg::REM_W-1:0] divr_ext;

	assign in_stall = v_q && out_stall;
	assign divr_ext = {1'b0, in_data.divr};
	assign take     = (in_data.rem >= divr_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!in_stall) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_q.rem   <= take ? in_data.rem - divr_ext : in_data.rem;
			data_q.divr  <= in_data.divr >> 1;
			data_q.quot  <= {in_data.quot[ipoc_pkg::QUOT_W-2:0], take};
			data_q.kind  <= in_data.kind;
			data_q.index <= in_data.index;
		end
	end

	assign out_valid = v_q;
	assign out_data  = data_q;

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && out_stall |=> v_q && $stable(data_q))
		else $error("divider cell dropped or changed a held item");

endmodule
